>>> rtl/core/masked_mean_and_stdev_macros.svh
// Assertion macros shared by the statistics block.
// Included by the top level; needs nothing else.
`ifndef MASKED_MEAN_AND_STDEV_MACROS_SVH
`define MASKED_MEAN_AND_STDEV_MACROS_SVH

// Check expr in the same cycle that cond holds.
`define MMS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Check expr in the cycle after cond holds.
`define MMS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/mms_pkg.sv
// Shared constants and types for the masked mean and deviation block.
// No dependencies; used by mms_addsub and masked_mean_and_stdev.
package mms_pkg;

    // Default configuration of the block
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_COUNT_DEF   = 65535;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed port widths
    localparam int SAMPLE_W    = 16;
    localparam int RESULT_W    = 24;
    localparam int COUNT_OUT_W = 16;

    // The sum of squares and the variance numerator wrap at this width
    localparam int WRAP_W = 64;

    // Default width of the shared adder
    localparam int ALU_W_DEF = 64;

    // Shared adder operation
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

>>> rtl/core/mms_addsub.sv
// Shared add/subtract unit used by every step of the result sequencer.
// Depends on mms_pkg for the operation code.
module mms_addsub
    import mms_pkg::*;
#(
    parameter int W = ALU_W_DEF
)(
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    input  alu_op_t      op,
    output logic [W-1:0] res,
    output logic         carry
);

    logic [W-1:0] b_eff;
    logic         cin;
    logic [W:0]   total;

    // Select operand polarity and carry in
    always_comb
    begin
        unique case (op)
            ALU_ADD:
            begin
                b_eff = op_b;
                cin   = 1'b0;
            end
            ALU_SUB:
            begin
                b_eff = ~op_b;
                cin   = 1'b1;
            end
        endcase
    end

    // Carry out of a subtract means op_a >= op_b
    assign total = {1'b0, op_a} + {1'b0, b_eff} + (W+1)'(cin);
    assign res   = total[W-1:0];
    assign carry = total[W];

endmodule

>>> rtl/core/masked_mean_and_stdev.sv
// Top level of the masked mean and standard deviation block.
// Depends on mms_pkg, mms_addsub and masked_mean_and_stdev_macros.svh.
//
// Usage:
//   Input channel item_valid/item_ready carries sample, include_req and last.
//   Items without last are taken one per cycle; an included sample updates
//   the count, sum and sum of squares in the transfer cycle, or at a full count sets the overflow flag.
//   An item with last closes the set. item_ready then drops while one shared
//   adder works through the result: n*sumsq (CNT_W steps), sum^2 (SUM_W
//   steps), one subtract, the square root (ROOT_W steps), root/n (ROOT_W
//   steps), one rounding add and the mean divide (NUM_W steps).
//   result_valid is registered and rises once the final state loads the result.
//   The result sits in an output register; the block keeps taking samples of
//   the next set while it waits. If the receiver stalls, a following last
//   item is held in the final state until the output register frees.
//   Accumulators clear when the result is loaded.
//   Reset clears the accumulators and the sequencer; no result is pending.
module masked_mean_and_stdev
    import mms_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_COUNT   = MAX_COUNT_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       include_req,
    input  logic                       last,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [RESULT_W-1:0] mean_value,
    output logic [RESULT_W-1:0]        std_dev,
    output logic [COUNT_OUT_W-1:0]     sample_count,
    output logic                       empty_set,
    output logic                       count_overflow
);

`include "masked_mean_and_stdev_macros.svh"

    // Widths derived from the parameters
    localparam int CNT_W   = $clog2(MAX_COUNT + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQR_W   = 2 * SAMPLE_BITS;
    localparam int SQ_FULL = CNT_W + 2 * SAMPLE_BITS - 2;
    localparam int SQ_W    = (SQ_FULL > WRAP_W) ? WRAP_W : SQ_FULL;
    localparam int D_FULL  = CNT_W + SQ_W;
    localparam int D_W     = (D_FULL > WRAP_W) ? WRAP_W : D_FULL;
    localparam int HOLD_W  = D_W + (D_W % 2);
    localparam int ROOT_W  = HOLD_W / 2 + FRAC_BITS;
    localparam int RW      = ROOT_W + 2;
    localparam int NUM_W   = SUM_W + FRAC_BITS + 1;
    localparam int QW      = (ROOT_W > NUM_W) ? ROOT_W : NUM_W;
    localparam int UW_A    = (D_W > RW) ? D_W : RW;
    localparam int UW      = (UW_A > NUM_W) ? UW_A : NUM_W;
    localparam int STEP_W  = $clog2(QW + 1);
    localparam int QX_W    = (NUM_W > RESULT_W) ? NUM_W : RESULT_W + 1;
    localparam int SX_W    = (ROOT_W > RESULT_W) ? ROOT_W : RESULT_W + 1;

    localparam int MEAN_POS_LIM = 2 ** (RESULT_W - 1) - 1;
    localparam int MEAN_NEG_MAG = 2 ** (RESULT_W - 1);
    localparam int RESULT_MAX   = 2 ** RESULT_W - 1;

    localparam logic [UW-1:0] D_MASK = {UW{1'b1}} >> (UW - D_W);

    typedef enum logic [3:0] {
        S_ACC,
        S_MULA,
        S_MULB,
        S_DIFF,
        S_SQRT,
        S_SDIV,
        S_MNUM,
        S_MDIV,
        S_OUT
    } state_t;

    // Control state
    state_t             state_reg, state_next;
    logic               result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SQ_W-1:0]    sumsq_reg, sumsq_next;
    logic               ovf_reg, ovf_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // Working and result registers
    logic [UW-1:0]       work_reg, work_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [RESULT_W-1:0] std_reg, std_next;
    logic [RESULT_W-1:0] mean_out_reg, mean_out_next;
    logic [RESULT_W-1:0] std_out_reg, std_out_next;
    logic [COUNT_OUT_W-1:0] count_out_reg, count_out_next;
    logic                empty_out_reg, empty_out_next;
    logic                ovf_out_reg, ovf_out_next;

    // Sample decode
    logic [SAMPLE_BITS-1:0]        raw;
    logic signed [SAMPLE_BITS-1:0] s_val;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [SQR_W-1:0]              sq;

    // Sequencer datapath
    logic               sum_neg;
    logic [SUM_W-1:0]   smag;
    logic [UW-1:0]      alu_a, alu_b, alu_res;
    alu_op_t            alu_op;
    logic               alu_carry;
    logic [RW-1:0]      rem_sq, trial;
    logic [CNT_W:0]     rem_dv;
    logic [UW-1:0]      mul_acc;
    logic               mul_bit;
    logic               step_last;
    logic [QW-1:0]      quo_shift;
    logic [QX_W-1:0]    q_ext;
    logic [SX_W-1:0]    sd_ext;
    logic [RESULT_W-1:0] mean_sat, std_sat;
    logic               load;

    // Take the low SAMPLE_BITS bits, sign-extend, square the magnitude
    assign raw   = SAMPLE_BITS'($unsigned(sample));
    assign s_val = $signed(raw);
    assign mag   = raw[SAMPLE_BITS-1] ? (~raw) + SAMPLE_BITS'(1) : raw;
    assign sq    = SQR_W'(mag) * SQR_W'(mag);

    // Magnitude of the running sum
    assign sum_neg = sum_reg[SUM_W-1];
    assign smag    = sum_neg ? (~sum_reg) + SUM_W'(1) : sum_reg;

    // Step operands
    assign rem_sq    = {work_reg[RW-3:0], hold_reg[HOLD_W-1 -: 2]};
    assign trial     = {quo_reg[ROOT_W-1:0], 2'b01};
    assign rem_dv    = {work_reg[CNT_W-1:0], quo_reg[QW-1]};
    assign mul_acc   = (work_reg << 1) & D_MASK;
    assign mul_bit   = quo_reg[QW-1];
    assign step_last = (step_reg == STEP_W'(1));
    assign quo_shift = {quo_reg[QW-2:0], alu_carry};

    // Saturate the mean and the deviation to the result width
    assign q_ext  = QX_W'(quo_reg[NUM_W-1:0]);
    assign sd_ext = SX_W'(quo_reg[ROOT_W-1:0]);

    always_comb
    begin
        if (sum_neg)
        begin
            mean_sat = (q_ext > QX_W'(MEAN_NEG_MAG)) ? RESULT_W'(MEAN_NEG_MAG)
                                                     : RESULT_W'(QX_W'(0) - q_ext);
        end
        else
        begin
            mean_sat = (q_ext > QX_W'(MEAN_POS_LIM)) ? RESULT_W'(MEAN_POS_LIM)
                                                     : RESULT_W'(q_ext);
        end
        std_sat = (sd_ext > SX_W'(RESULT_MAX)) ? RESULT_W'(RESULT_MAX) : RESULT_W'(sd_ext);
    end

    // Route operands to the shared adder
    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        unique case (state_reg)
            S_MULA:
            begin
                alu_a = mul_acc;
                alu_b = mul_bit ? UW'(sumsq_reg) : '0;
            end
            S_MULB:
            begin
                alu_a = mul_acc;
                alu_b = mul_bit ? UW'(smag) : '0;
            end
            S_DIFF:
            begin
                alu_a  = UW'(hold_reg);
                alu_b  = work_reg;
                alu_op = ALU_SUB;
            end
            S_SQRT:
            begin
                alu_a  = UW'(rem_sq);
                alu_b  = UW'(trial);
                alu_op = ALU_SUB;
            end
            S_SDIV, S_MDIV:
            begin
                alu_a  = UW'(rem_dv);
                alu_b  = UW'(count_reg);
                alu_op = ALU_SUB;
            end
            S_MNUM:
            begin
                alu_a = UW'(smag) << FRAC_BITS;
                alu_b = UW'(count_reg >> 1);
            end
            S_ACC, S_OUT:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    mms_addsub #(
        .W (UW)
    ) u_addsub (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .op    (alu_op),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign item_ready = (state_reg == S_ACC);
    assign load       = (state_reg == S_OUT) && (!result_valid_reg || result_ready);

    // Accumulate, sequence the result steps, load the output register
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        sumsq_next        = sumsq_reg;
        ovf_next          = ovf_reg;
        step_next         = step_reg;
        work_next         = work_reg;
        hold_next         = hold_reg;
        quo_next          = quo_reg;
        std_next          = std_reg;
        mean_out_next     = mean_out_reg;
        std_out_next      = std_out_reg;
        count_out_next    = count_out_reg;
        empty_out_next    = empty_out_reg;
        ovf_out_next      = ovf_out_reg;

        // Drop the result after its transfer
        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_ACC:
            begin
                if (item_valid)
                begin
                    if (include_req)
                    begin
                        if (count_reg == CNT_W'(MAX_COUNT))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            sum_next   = sum_reg + SUM_W'(s_val);
                            sumsq_next = sumsq_reg + SQ_W'(sq);
                        end
                    end
                    if (last)
                    begin
                        quo_next   = QW'(count_next) << (QW - CNT_W);
                        work_next  = '0;
                        step_next  = STEP_W'(CNT_W);
                        state_next = S_MULA;
                    end
                end
            end
            S_MULA:
            begin
                work_next = alu_res & D_MASK;
                quo_next  = quo_reg << 1;
                step_next = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    hold_next  = HOLD_W'(alu_res & D_MASK);
                    work_next  = '0;
                    quo_next   = QW'(smag) << (QW - SUM_W);
                    step_next  = STEP_W'(SUM_W);
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                work_next = alu_res & D_MASK;
                quo_next  = quo_reg << 1;
                step_next = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                // Clamp a negative numerator to zero
                hold_next  = alu_carry ? HOLD_W'(alu_res) : '0;
                work_next  = '0;
                quo_next   = '0;
                step_next  = STEP_W'(ROOT_W);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                work_next = alu_carry ? alu_res : UW'(rem_sq);
                quo_next  = quo_shift;
                hold_next = hold_reg << 2;
                step_next = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    quo_next   = quo_shift << (QW - ROOT_W);
                    work_next  = '0;
                    step_next  = STEP_W'(ROOT_W);
                    state_next = S_SDIV;
                end
            end
            S_SDIV:
            begin
                work_next = alu_carry ? alu_res : UW'(rem_dv);
                quo_next  = quo_shift;
                step_next = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    state_next = S_MNUM;
                end
            end
            S_MNUM:
            begin
                std_next   = std_sat;
                quo_next   = QW'(alu_res[NUM_W-1:0]) << (QW - NUM_W);
                work_next  = '0;
                step_next  = STEP_W'(NUM_W);
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                work_next = alu_carry ? alu_res : UW'(rem_dv);
                quo_next  = quo_shift;
                step_next = step_reg - STEP_W'(1);
                if (step_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load)
                begin
                    result_valid_next = 1'b1;
                    empty_out_next    = (count_reg == '0);
                    mean_out_next     = (count_reg == '0) ? '0 : mean_sat;
                    std_out_next      = (count_reg == '0) ? '0 : std_reg;
                    count_out_next    = COUNT_OUT_W'(count_reg);
                    ovf_out_next      = ovf_reg;
                    count_next        = '0;
                    sum_next          = '0;
                    sumsq_next        = '0;
                    ovf_next          = 1'b0;
                    state_next        = S_ACC;
                end
            end
        endcase
    end

    // Hold sequencer state, accumulators and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_ACC;
            result_valid_reg <= 1'b0;
            count_reg        <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
            ovf_reg          <= 1'b0;
            step_reg         <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            count_reg        <= count_next;
            sum_reg          <= sum_next;
            sumsq_reg        <= sumsq_next;
            ovf_reg          <= ovf_next;
            step_reg         <= step_next;
        end
    end

    // Advance working registers and result payload
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        hold_reg      <= hold_next;
        quo_reg       <= quo_next;
        std_reg       <= std_next;
        mean_out_reg  <= mean_out_next;
        std_out_reg   <= std_out_next;
        count_out_reg <= count_out_next;
        empty_out_reg <= empty_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign result_valid   = result_valid_reg;
    assign mean_value     = mean_out_reg;
    assign std_dev        = std_out_reg;
    assign sample_count   = count_out_reg;
    assign empty_set      = empty_out_reg;
    assign count_overflow = ovf_out_reg;

    // Closing a set stops intake on the next cycle
    `MMS_ASSERT_NEXT(a_last_blocks_intake, clk, rst_n, item_valid && item_ready && last, !item_ready, "intake still open after last transfer")

    // Saturating count never passes its bound
    `MMS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_COUNT), "count above bound")

    // Empty set gives zero mean and deviation
    `MMS_ASSERT_NOW(a_empty_zero, clk, rst_n, result_valid && empty_set, mean_value == '0 && std_dev == '0, "empty set with nonzero result")

    // Loading a result presents it and clears the accumulators
    `MMS_ASSERT_NEXT(a_load_clears, clk, rst_n, load, result_valid && count_reg == '0 && sum_reg == '0 && !ovf_reg, "result load did not clear state")

    // Iterating states always have steps left
    `MMS_ASSERT_NOW(a_step_live, clk, rst_n, state_reg == S_MULA || state_reg == S_MULB || state_reg == S_SQRT || state_reg == S_SDIV || state_reg == S_MDIV, step_reg != '0, "iteration with no steps left")

endmodule
